// File: src/sm4_pkg.sv
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared types, constants and round functions of the SM4 block cipher.
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1
  } cfg_reg_t;

  // Pipeline stage payload: four state words and the direction bit.
  typedef struct packed {
    logic [3:0][31:0] x;
    logic             decrypt;
  } stage_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } result_t;

  localparam logic [31:0] FK [4] = '{32'ha3b1bac6, 32'h56aa3350,
                                     32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Byte-wise S-box substitution.
  function automatic logic [31:0] tau(input logic [31:0] v);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = SBOX[v[8*b +: 8]];
    end
    return r;
  endfunction

  // Linear transform of the data rounds.
  function automatic logic [31:0] l_data(input logic [31:0] t);
    return t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
  endfunction

  // Linear transform of the key schedule.
  function automatic logic [31:0] l_key(input logic [31:0] t);
    return t ^ rotl(t, 13) ^ rotl(t, 23);
  endfunction

  // CK word i: byte j is (4*i + j) * 7 mod 256.
  function automatic logic [31:0] ck_word(input logic [7:0] idx);
    logic [31:0] w;
    logic [7:0]  tmp;
    for (int j = 0; j < 4; j++) begin
      tmp = {idx[5:0], 2'b00} + 8'(j);
      w[8*(3-j) +: 8] = 8'({tmp, 3'b000} - {3'b000, tmp});
    end
    return w;
  endfunction

  // One data round: shift the words and append the new one.
  function automatic stage_t round_f(input stage_t s, input logic [31:0] rk);
    stage_t r;
    r.decrypt = s.decrypt;
    r.x[0]    = s.x[1];
    r.x[1]    = s.x[2];
    r.x[2]    = s.x[3];
    r.x[3]    = s.x[0] ^ l_data(tau(s.x[1] ^ s.x[2] ^ s.x[3] ^ rk));
    return r;
  endfunction

endpackage

// File: src/sm4_in_if.sv
// ----------------------------------------------------------------------------
// sm4_in_if
// Input block channel: valid/ready handshake with the plaintext or ciphertext.
// ----------------------------------------------------------------------------
interface sm4_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        decrypt;

  modport source(output valid, block_high, block_low, decrypt, input ready);
  modport sink(input valid, block_high, block_low, decrypt, output ready);
endinterface

// File: src/sm4_out_if.sv
// ----------------------------------------------------------------------------
// sm4_out_if
// Result block channel: valid/ready handshake with the processed block.
// ----------------------------------------------------------------------------
interface sm4_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source(output valid, result_high, result_low, input ready);
  modport sink(input valid, result_high, result_low, output ready);
endinterface

// File: src/sm4_key_exp.sv
// ----------------------------------------------------------------------------
// sm4_key_exp
// Key registers and iterative key schedule, one round key per cycle.
// ----------------------------------------------------------------------------
module sm4_key_exp import sm4_pkg::*; #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   busy,
  output logic [31:0]            rk [ROUND_COUNT]
);

  localparam int CW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  logic [63:0]      key_high;
  logic [63:0]      key_low;
  logic [63:0]      key_high_next;
  logic [63:0]      key_low_next;
  logic [3:0][31:0] k;
  logic [31:0]      nk;
  logic [CW-1:0]    cnt;
  logic             key_wr;

  assign key_wr = cfg_wr_en &&
                  (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

  always_comb begin
    key_high_next = key_high;
    key_low_next  = key_low;
    if (cfg_wr_en && cfg_index == REG_KEY_HIGH) begin
      key_high_next = cfg_data;
    end
    if (cfg_wr_en && cfg_index == REG_KEY_LOW) begin
      key_low_next = cfg_data;
    end
  end

  assign nk = k[0] ^ l_key(tau(k[1] ^ k[2] ^ k[3] ^ ck_word(8'(cnt))));

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      k        <= {FK[3], FK[2], FK[1], FK[0]};
      cnt      <= '0;
      busy     <= 1'b1;
    end else if (key_wr) begin
      // restart the schedule from the updated key
      key_high <= key_high_next;
      key_low  <= key_low_next;
      k        <= {key_low_next[31:0] ^ FK[3], key_low_next[63:32] ^ FK[2],
                   key_high_next[31:0] ^ FK[1], key_high_next[63:32] ^ FK[0]};
      cnt      <= '0;
      busy     <= 1'b1;
    end else if (busy) begin
      k   <= {nk, k[3], k[2], k[1]};
      cnt <= cnt + 1'b1;
      if (cnt == CW'(ROUND_COUNT - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !key_wr) begin
      rk[cnt] <= nk;
    end
  end

endmodule

// File: src/sm4_round.sv
// ----------------------------------------------------------------------------
// sm4_round
// One registered cipher round of the block pipeline.
// ----------------------------------------------------------------------------
module sm4_round import sm4_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  stage_t      in_data,
  input  logic [31:0] rk_fwd,
  input  logic [31:0] rk_rev,
  output logic        out_valid,
  output stage_t      out_data
);

  logic [31:0] rk;

  assign rk = in_data.decrypt ? rk_rev : rk_fwd;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= round_f(in_data, rk);
    end
  end

endmodule

// File: src/sm4_block_cipher.sv
// Each input transaction passes the 32 round stages and the output register
// before the result is valid. Throughput: one block per cycle unless stalled.
// Round keys live in flip-flops; each pipeline stage reads its own key pair.
// Reset and every key register write start the key schedule, one round
// key per cycle, during which no input transaction is taken.
// Reset is synchronous, active high, and clears all valid bits.
// ----------------------------------------------------------------------------
// sm4_block_cipher
// SM4 encrypt/decrypt engine with a fully unrolled round pipeline.
// ----------------------------------------------------------------------------
module sm4_block_cipher import sm4_pkg::*; #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  sm4_in_if.sink                 blk_in,
  sm4_out_if.source              blk_out
);

  logic        kx_busy;
  logic [31:0] rk [ROUND_COUNT];

  logic        adv;
  logic        vld [ROUND_COUNT+1];
  stage_t      st  [ROUND_COUNT+1];

  logic        ov;
  result_t     od;
  logic        sv;
  result_t     sd;
  logic        leave;
  result_t     pipe_res;

  sm4_key_exp #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_key_exp (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .busy     (kx_busy),
    .rk       (rk)
  );

  // the pipeline moves whenever the skid slot is free
  assign adv          = !sv;
  assign blk_in.ready = adv && !kx_busy;

  assign vld[0]        = blk_in.valid && !kx_busy;
  assign st[0].decrypt = blk_in.decrypt;
  assign st[0].x[0]    = blk_in.block_high[63:32];
  assign st[0].x[1]    = blk_in.block_high[31:0];
  assign st[0].x[2]    = blk_in.block_low[63:32];
  assign st[0].x[3]    = blk_in.block_low[31:0];

  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    sm4_round u_round (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (vld[i]),
      .in_data  (st[i]),
      .rk_fwd   (rk[i]),
      .rk_rev   (rk[ROUND_COUNT-1-i]),
      .out_valid(vld[i+1]),
      .out_data (st[i+1])
    );
  end

  assign leave                = adv && vld[ROUND_COUNT];
  assign pipe_res.result_high = {st[ROUND_COUNT].x[3], st[ROUND_COUNT].x[2]};
  assign pipe_res.result_low  = {st[ROUND_COUNT].x[1], st[ROUND_COUNT].x[0]};

  // output register backed by one skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || blk_out.ready) begin
      ov <= sv || leave;
      sv <= 1'b0;
    end else if (leave) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || blk_out.ready) begin
      od <= sv ? sd : pipe_res;
    end
    if (ov && !blk_out.ready && leave) begin
      sd <= pipe_res;
    end
  end

  assign blk_out.valid       = ov;
  assign blk_out.result_high = od.result_high;
  assign blk_out.result_low  = od.result_low;

  a_no_accept_in_keysched: assert property (@(posedge clk) disable iff (rst)
    blk_in.valid && blk_in.ready |-> !kx_busy)
    else $error("input transaction taken during key schedule");

  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov)
    else $error("skid slot full while output register empty");

  a_key_write_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW)
    |=> kx_busy)
    else $error("key write did not start the key schedule");

  a_stall_holds_skid: assert property (@(posedge clk) disable iff (rst)
    sv && !blk_out.ready |=> sv && $stable(sd))
    else $error("skid slot lost its transaction under stall");

endmodule
